### rtl/mfb_pkg.sv
// Shared types, codes and constants of the monochrome framebuffer blit engine.
package mfb_pkg;

  localparam int COLUMNS_DEFAULT = 128;
  localparam int PAGES_DEFAULT   = 8;
  localparam int QUEUE_DEPTH     = 2;

  // Item kinds as carried on the slave tuser field.
  typedef enum logic [2:0] {
    MODE_WRITE = 3'd0,
    MODE_SET   = 3'd1,
    MODE_GET   = 3'd2,
    MODE_READ  = 3'd3,
    MODE_CLEAR = 3'd4
  } mfb_mode_t;

  // Operations handed from the front to the back.
  typedef enum logic [1:0] {
    OP_RMW   = 2'd0,
    OP_READ  = 2'd1,
    OP_CLEAR = 2'd2
  } mfb_op_t;

  // One classified command. The masks span the addressed page (low byte)
  // and the page below it (high byte).
  typedef struct packed {
    mfb_op_t     op;
    logic [4:0]  page;
    logic [7:0]  col;
    logic        hi_en;
    logic [15:0] clr_mask;
    logic [15:0] or_mask;
    logic        pixel;
    logic [2:0]  shift;
    logic        off;
  } mfb_cmd_t;

  // Status from the back to the front.
  typedef struct packed {
    logic init_busy;
    logic sweep;
  } mfb_status_t;

endpackage

### rtl/mfb_ram.sv
// Generic single-write, single-read RAM with registered read data.
module mfb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/mfb_front.sv
// Front end: accepts items, clips them to the screen and builds commands.
module mfb_front #(
  parameter int COLUMNS = mfb_pkg::COLUMNS_DEFAULT,
  parameter int PAGES   = mfb_pkg::PAGES_DEFAULT
) (
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [31:0]         s_tdata,
  input  logic [2:0]          s_tuser,
  input  mfb_pkg::mfb_status_t status,
  input  logic                q_ready,
  output logic                q_push,
  output mfb_pkg::mfb_cmd_t   q_cmd
);

  logic [7:0]  x;
  logic [7:0]  y;
  logic [7:0]  data_byte;
  logic [3:0]  nclr_raw;
  logic [3:0]  nclr;
  logic [2:0]  sh;
  logic [4:0]  page;
  logic        x_ok;
  logic        page_ok;
  logic        hi_ok;
  logic [8:0]  run;
  logic [15:0] clr16;
  logic [15:0] or16;
  logic        keep;

  assign x         = s_tdata[7:0];
  assign y         = s_tdata[15:8];
  assign data_byte = s_tdata[23:16];
  assign nclr_raw  = s_tdata[27:24];
  assign sh        = y[2:0];
  assign page      = y[7:3];

  assign x_ok    = {1'b0, x} < 9'(COLUMNS);
  assign page_ok = {1'b0, page} < 6'(PAGES);
  assign hi_ok   = ({1'b0, page} + 6'd1) < 6'(PAGES);

  assign nclr  = (nclr_raw > 4'd8) ? 4'd8 : nclr_raw;
  assign run   = (9'd1 << nclr) - 9'd1;
  assign clr16 = {8'd0, run[7:0]} << sh;
  assign or16  = {8'd0, data_byte} << sh;

  // No item enters while the store is being blanked after reset.
  assign s_tready = q_ready && !status.init_busy;

  always_comb begin
    q_cmd          = '0;
    q_cmd.op       = mfb_pkg::OP_RMW;
    q_cmd.page     = page;
    q_cmd.col      = x;
    q_cmd.shift    = sh;
    q_cmd.off      = !(x_ok && page_ok);
    keep           = 1'b0;
    case (s_tuser)
      mfb_pkg::MODE_WRITE: begin
        q_cmd.clr_mask = clr16;
        q_cmd.or_mask  = or16;
        q_cmd.hi_en    = hi_ok && (sh != 3'd0);
        keep           = x_ok && page_ok;
      end
      mfb_pkg::MODE_SET: begin
        q_cmd.or_mask = 16'd1 << sh;
        keep          = x_ok && page_ok;
      end
      mfb_pkg::MODE_GET: begin
        q_cmd.op    = mfb_pkg::OP_READ;
        q_cmd.pixel = 1'b1;
        keep        = 1'b1;
      end
      mfb_pkg::MODE_READ: begin
        q_cmd.op = mfb_pkg::OP_READ;
        keep     = 1'b1;
      end
      mfb_pkg::MODE_CLEAR: begin
        q_cmd.op = mfb_pkg::OP_CLEAR;
        keep     = 1'b1;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  // Clipped writes and unused kinds are taken and dropped here.
  assign q_push = s_tvalid && s_tready && keep;

endmodule

### rtl/mfb_queue.sv
// Short command queue between the front end and the back end.
module mfb_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  mfb_pkg::mfb_cmd_t push_cmd,
  output logic              ready,
  output logic              valid,
  output mfb_pkg::mfb_cmd_t head,
  input  logic              pop
);

  localparam int DEPTH = mfb_pkg::QUEUE_DEPTH;
  localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW    = $clog2(DEPTH + 1);

  mfb_pkg::mfb_cmd_t entries [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          do_pop;

  assign ready  = count != CW'(DEPTH);
  assign valid  = count != '0;
  assign head   = entries[rd_ptr];
  assign do_pop = pop && valid;

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      count <= count + CW'(push) - CW'(do_pop);
    end
  end

endmodule

### rtl/mfb_back.sv
// Back end: executes commands against the frame store and drives results.
module mfb_back #(
  parameter int COLUMNS = mfb_pkg::COLUMNS_DEFAULT,
  parameter int PAGES   = mfb_pkg::PAGES_DEFAULT
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 q_valid,
  input  mfb_pkg::mfb_cmd_t    q_head,
  output logic                 q_pop,
  output mfb_pkg::mfb_status_t status,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [15:0]          m_tdata
);

  localparam int DEPTH = PAGES * COLUMNS;
  localparam int AW    = $clog2(DEPTH);

  typedef enum logic [4:0] {
    ST_CLEAR = 5'b00001,
    ST_IDLE  = 5'b00010,
    ST_LO    = 5'b00100,
    ST_HI    = 5'b01000,
    ST_READ  = 5'b10000
  } mfb_state_t;

  mfb_state_t        state;
  mfb_state_t        state_next;
  mfb_pkg::mfb_cmd_t cur;
  logic [AW-1:0]     clear_pointer;
  logic              init_done;
  logic [AW-1:0]     head_addr;
  logic [AW-1:0]     cur_addr;
  logic [AW-1:0]     hi_addr;
  logic              we;
  logic [AW-1:0]     waddr;
  logic [7:0]        wdata;
  logic [AW-1:0]     raddr;
  logic [7:0]        rdata;
  logic              out_free;
  logic              load_out;
  logic [7:0]        rd_value;

  assign head_addr = AW'(32'(q_head.page) * COLUMNS + 32'(q_head.col));
  assign cur_addr  = AW'(32'(cur.page) * COLUMNS + 32'(cur.col));
  assign hi_addr   = cur_addr + AW'(COLUMNS);

  mfb_ram #(
    .WIDTH(8),
    .DEPTH(DEPTH)
  ) u_store (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rdata)
  );

  assign out_free = !m_tvalid || m_tready;
  assign rd_value = cur.off ? 8'd0 :
                    cur.pixel ? {7'd0, rdata[cur.shift]} : rdata;

  always_comb begin
    state_next = state;
    q_pop      = 1'b0;
    we         = 1'b0;
    waddr      = cur_addr;
    wdata      = 8'd0;
    raddr      = cur_addr;
    load_out   = 1'b0;
    case (state)
      ST_CLEAR: begin
        we    = 1'b1;
        waddr = clear_pointer;
        if (clear_pointer == AW'(DEPTH - 1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        raddr = head_addr;
        if (q_valid) begin
          q_pop = 1'b1;
          case (q_head.op)
            mfb_pkg::OP_RMW:   state_next = ST_LO;
            mfb_pkg::OP_READ:  state_next = ST_READ;
            mfb_pkg::OP_CLEAR: state_next = ST_CLEAR;
            default:           state_next = ST_IDLE;
          endcase
        end
      end
      ST_LO: begin
        we    = 1'b1;
        wdata = (rdata & ~cur.clr_mask[7:0]) | cur.or_mask[7:0];
        if (cur.hi_en) begin
          raddr      = hi_addr;
          state_next = ST_HI;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_HI: begin
        we         = 1'b1;
        waddr      = hi_addr;
        wdata      = (rdata & ~cur.clr_mask[15:8]) | cur.or_mask[15:8];
        state_next = ST_IDLE;
      end
      ST_READ: begin
        if (out_free) begin
          load_out   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_CLEAR;
      clear_pointer <= '0;
      init_done     <= 1'b0;
      m_tvalid      <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) begin
        if (clear_pointer == AW'(DEPTH - 1)) begin
          clear_pointer <= '0;
          init_done     <= 1'b1;
        end else begin
          clear_pointer <= clear_pointer + AW'(1);
        end
      end
      if (load_out) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur <= q_head;
    end
    if (load_out) begin
      m_tdata <= {7'd0, cur.off, rd_value};
    end
  end

  assign status.init_busy = !init_done;
  assign status.sweep     = state == ST_CLEAR;

endmodule

### rtl/mono_framebuffer_blit_engine.sv
// Top level of the monochrome framebuffer blit engine.
//
// The engine keeps a COLUMNS x (8*PAGES) one-bit display store (128x64 by
// default), organized as PAGES pages of COLUMNS column bytes; bit n of a
// byte is pixel row 8*page+n. Each transaction on the slave stream carries
// one item whose kind sits in tuser: write column byte, set pixel, get
// pixel, read byte, or clear all. Get pixel and read byte each return one
// transaction on the master stream; the other kinds return nothing, and
// writes that fall off the screen are dropped silently. A front end
// classifies items and clips them, and a two-entry command queue lets it
// keep taking items while the back end works through the store. The store
// is one RAM with a single write and a single registered read port, and
// the back end sequences each command over that port: a read addresses the
// store from the idle state and loads the result register once it is free,
// a set pixel or a byte write that stays inside one page reads and rewrites
// that byte, a byte write that straddles two pages reads and rewrites both
// page bytes in turn, and a clear all writes every store byte, one store
// byte per cycle. After reset the engine blanks all PAGES*COLUMNS bytes of
// the store (1024 by default) the same way, while s_axis_tready stays low.
module mono_framebuffer_blit_engine #(
  parameter int COLUMNS = mfb_pkg::COLUMNS_DEFAULT,
  parameter int PAGES   = mfb_pkg::PAGES_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // Fields from bit 0 up: x[7:0], y[15:8], data[23:16],
  // rows_to_clear[27:24], zero fill[31:28].
  input  logic [31:0] s_axis_tdata,
  // Fields from bit 0 up: mode[2:0].
  input  logic [2:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // Fields from bit 0 up: read_value[7:0], off_screen[8], zero fill[15:9].
  output logic [15:0] m_axis_tdata
);

  mfb_pkg::mfb_status_t status;
  mfb_pkg::mfb_cmd_t    push_cmd;
  mfb_pkg::mfb_cmd_t    head_cmd;
  logic                 q_push;
  logic                 q_ready;
  logic                 q_valid;
  logic                 q_pop;

  // The front end classifies each accepted item into a command.
  mfb_front #(
    .COLUMNS(COLUMNS),
    .PAGES  (PAGES)
  ) u_front (
    .s_tvalid(s_axis_tvalid),
    .s_tready(s_axis_tready),
    .s_tdata (s_axis_tdata),
    .s_tuser (s_axis_tuser),
    .status  (status),
    .q_ready (q_ready),
    .q_push  (q_push),
    .q_cmd   (push_cmd)
  );

  // Commands wait here until the back end is free.
  mfb_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (q_push),
    .push_cmd(push_cmd),
    .ready   (q_ready),
    .valid   (q_valid),
    .head    (head_cmd),
    .pop     (q_pop)
  );

  // The back end owns the frame store and the result register.
  mfb_back #(
    .COLUMNS(COLUMNS),
    .PAGES  (PAGES)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_head  (head_cmd),
    .q_pop   (q_pop),
    .status  (status),
    .m_tvalid(m_axis_tvalid),
    .m_tready(m_axis_tready),
    .m_tdata (m_axis_tdata)
  );

  // The blanking pass after reset must hold off every input item.
  assert property (@(posedge clk) disable iff (rst)
    status.init_busy |-> !s_axis_tready)
    else $error("input accepted while the store is still being blanked");

  // Leaving reset always starts with the store sweep.
  assert property (@(posedge clk)
    $fell(rst) |-> (status.init_busy && status.sweep))
    else $error("store sweep did not start after reset");

  // An off-screen read answers with a zero value.
  assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tdata[8]) |-> (m_axis_tdata[7:0] == 8'd0))
    else $error("off-screen read returned a nonzero value");

  // A command is never pushed into a full queue.
  assert property (@(posedge clk) disable iff (rst)
    q_push |-> q_ready)
    else $error("command pushed into a full queue");

endmodule

### tb/mfb_checker.sv
// Shadow framebuffer that predicts read replies and compares them with the master stream.
module mfb_checker #(
  parameter int COLUMNS = mfb_pkg::COLUMNS_DEFAULT,
  parameter int PAGES   = mfb_pkg::PAGES_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  // Fields from bit 0 up: x[7:0], y[15:8], data[23:16], rows_to_clear[27:24].
  input  logic [31:0] s_axis_tdata,
  // Fields from bit 0 up: mode[2:0].
  input  logic [2:0]  s_axis_tuser,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // Fields from bit 0 up: read_value[7:0], off_screen[8].
  input  logic [15:0] m_axis_tdata,
  output int          error_count,
  output int          pending_reads
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ROWS = 8 * PAGES;

  typedef struct packed {
    logic [7:0] read_value;
    logic       off_screen;
  } read_reply_t;

  logic [7:0]  shadow_frame [PAGES*COLUMNS];
  read_reply_t expected_reads [$];
  int          errs = 0;

  // Applies one accepted item to the shadow store and queues its reply, if any.
  task automatic blit_item(input logic [2:0] kind, input logic [7:0] x, input logic [7:0] y,
                           input logic [7:0] data, input logic [3:0] nclr);
    int unsigned shift;
    int unsigned page;
    int unsigned rows;
    int unsigned row;
    int unsigned k;
    logic [15:0] spread;
    read_reply_t reply;
    shift = y % 8;
    page  = y / 8;
    reply = '0;
    case (kind)
      mfb_pkg::MODE_WRITE: begin
        rows = (nclr > 8) ? 8 : nclr;
        for (k = 0; k < rows; k++) begin
          row = y + k;
          if (x < COLUMNS && row < ROWS)
            shadow_frame[(row / 8) * COLUMNS + x][row % 8] = 1'b0;
        end
        // The shifted byte spans the addressed page and the one below it.
        spread = {8'h00, data} << shift;
        if (x < COLUMNS && page < PAGES)
          shadow_frame[page * COLUMNS + x] |= spread[7:0];
        if (x < COLUMNS && page + 1 < PAGES)
          shadow_frame[(page + 1) * COLUMNS + x] |= spread[15:8];
      end
      mfb_pkg::MODE_SET: begin
        if (x < COLUMNS && y < ROWS)
          shadow_frame[page * COLUMNS + x][shift] = 1'b1;
      end
      mfb_pkg::MODE_GET: begin
        if (x < COLUMNS && y < ROWS)
          reply.read_value = {7'd0, shadow_frame[page * COLUMNS + x][shift]};
        else
          reply.off_screen = 1'b1;
        expected_reads.push_back(reply);
      end
      mfb_pkg::MODE_READ: begin
        if (x < COLUMNS && page < PAGES)
          reply.read_value = shadow_frame[page * COLUMNS + x];
        else
          reply.off_screen = 1'b1;
        expected_reads.push_back(reply);
      end
      mfb_pkg::MODE_CLEAR: begin
        for (k = 0; k < PAGES * COLUMNS; k++)
          shadow_frame[k] = 8'h00;
      end
      default: begin
      end
    endcase
  endtask

  always @(posedge clk) begin
    read_reply_t want;
    if (rst) begin
      for (int i = 0; i < PAGES * COLUMNS; i++)
        shadow_frame[i] = 8'h00;
      expected_reads.delete();
    end else begin
      // Replies are popped first: an item accepted at this edge cannot be answered yet.
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_reads.size() == 0) begin
          $error("reply with no read pending: data %0h", m_axis_tdata);
          errs++;
        end else begin
          want = expected_reads.pop_front();
          if (m_axis_tdata[7:0] !== want.read_value) begin
            $error("read_value expected %0h actual %0h", want.read_value, m_axis_tdata[7:0]);
            errs++;
          end
          if (m_axis_tdata[8] !== want.off_screen) begin
            $error("off_screen expected %0b actual %0b", want.off_screen, m_axis_tdata[8]);
            errs++;
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready)
        blit_item(s_axis_tuser, s_axis_tdata[7:0], s_axis_tdata[15:8], s_axis_tdata[23:16],
                  s_axis_tdata[27:24]);
    end
    error_count   <= errs;
    pending_reads <= expected_reads.size();
  end

endmodule

### tb/mono_framebuffer_blit_engine_test.sv
// Stimulus and verdict for the monochrome framebuffer blit engine.
module mono_framebuffer_blit_engine_test;
  timeunit 1ns;
  timeprecision 1ps;

  // Random items to send in each of the three idling phases.
  localparam int PHASE_ITEMS = 515;
  // Length of the long receiver hold-off, in clock cycles.
  localparam int LONG_HOLD   = 400;
  // A clear all walks the whole store, one byte per cycle.
  localparam int CLEAR_CYCLES = mfb_pkg::PAGES_DEFAULT * mfb_pkg::COLUMNS_DEFAULT + 1;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;
  logic [2:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;
  int          error_count;
  int          pending_reads;

  // Idle rates of the two sides, in percent, changed from phase to phase.
  int tx_idle_pct = 38;
  int rx_idle_pct = 55;
  // Raised once by the stimulus to ask the receiver for its long hold-off.
  bit long_hold_go = 1'b0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  mono_framebuffer_blit_engine DUT (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  mfb_checker u_checker (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .error_count   (error_count),
    .pending_reads (pending_reads)
  );

  // Receiver: random back-pressure, plus one long hold-off counted here so that
  // the two-entry command queue fills and the engine stalls its input stream.
  initial begin
    int  hold_left;
    bit  hold_used;
    hold_left = 0;
    hold_used = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else if (long_hold_go && !hold_used) begin
        hold_used = 1'b1;
        hold_left = LONG_HOLD - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
      end
    end
  end

  // Offers one item and returns at the edge where its transaction completes.
  // Idle cycles come first, so tvalid only drops between items when a gap is
  // actually taken, and is never lowered and raised at the same edge.
  task automatic send_item(input logic [2:0] kind, input logic [7:0] x, input logic [7:0] y,
                           input logic [7:0] data, input logic [3:0] nclr);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= {4'd0, nclr, data, y, x};
    do
      @(posedge clk);
    while (!s_axis_tready);
  endtask

  // Builds one random item. Half of the items stay in a small corner of the
  // screen so that reads land on pixels that earlier writes have touched.
  task automatic send_random_item(output bit counted);
    int         pick;
    logic [2:0] kind;
    logic [7:0] x;
    logic [7:0] y;
    logic [3:0] nclr;
    pick = $urandom_range(0, 99);
    if (pick < 30)      kind = mfb_pkg::MODE_WRITE;
    else if (pick < 48) kind = mfb_pkg::MODE_SET;
    else if (pick < 68) kind = mfb_pkg::MODE_GET;
    else if (pick < 91) kind = mfb_pkg::MODE_READ;
    else if (pick < 92) kind = mfb_pkg::MODE_CLEAR;
    else                kind = 3'($urandom_range(5, 7));
    if ($urandom_range(0, 1) == 0) begin
      x = 8'($urandom_range(0, 7));
      y = 8'($urandom_range(0, 23));
    end else begin
      x = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(128, 255))
                                      : 8'($urandom_range(0, 127));
      y = ($urandom_range(0, 6) == 0) ? 8'($urandom_range(64, 255))
                                      : 8'($urandom_range(0, 63));
    end
    nclr = ($urandom_range(0, 4) == 0) ? 4'($urandom_range(9, 15)) : 4'($urandom_range(0, 8));
    send_item(kind, x, y, 8'($urandom()), nclr);
    counted = (kind <= mfb_pkg::MODE_CLEAR);
  endtask

  // Holds the sender back until every queued read has been answered.
  task automatic wait_for_replies(input int settle);
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_reads != 0)
      @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  task automatic random_phase;
    int sent;
    bit counted;
    sent = 0;
    while (sent < PHASE_ITEMS) begin
      send_random_item(counted);
      if (counted)
        sent++;
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Directed part. The engine blanks its store after reset and holds
    // tready low meanwhile; the first transaction simply waits for that.
    send_item(mfb_pkg::MODE_GET,   8'd0,   8'd0,   8'h00, 4'd0);   // blank screen reads zero
    send_item(mfb_pkg::MODE_READ,  8'd0,   8'd0,   8'h00, 4'd0);
    send_item(mfb_pkg::MODE_SET,   8'd0,   8'd0,   8'h00, 4'd0);   // corner pixels
    send_item(mfb_pkg::MODE_SET,   8'd127, 8'd63,  8'h00, 4'd0);
    send_item(mfb_pkg::MODE_SET,   8'd128, 8'd0,   8'h00, 4'd0);   // column off screen
    send_item(mfb_pkg::MODE_SET,   8'd0,   8'd64,  8'h00, 4'd0);   // row off screen
    send_item(mfb_pkg::MODE_GET,   8'd0,   8'd0,   8'h00, 4'd0);
    send_item(mfb_pkg::MODE_GET,   8'd127, 8'd63,  8'h00, 4'd0);
    send_item(mfb_pkg::MODE_GET,   8'd255, 8'd255, 8'h00, 4'd0);
    send_item(mfb_pkg::MODE_GET,   8'd5,   8'd64,  8'h00, 4'd0);
    send_item(mfb_pkg::MODE_WRITE, 8'd10,  8'd0,   8'hFF, 4'd0);   // aligned byte
    send_item(mfb_pkg::MODE_WRITE, 8'd10,  8'd3,   8'hA5, 4'd8);   // straddles two pages
    send_item(mfb_pkg::MODE_READ,  8'd10,  8'd0,   8'h00, 4'd0);
    send_item(mfb_pkg::MODE_READ,  8'd10,  8'd8,   8'h00, 4'd0);
    // Lower page missing, and a clear count above eight.
    send_item(mfb_pkg::MODE_WRITE, 8'd20,  8'd61,  8'hFF, 4'd15);
    send_item(mfb_pkg::MODE_READ,  8'd20,  8'd56,  8'h00, 4'd0);
    send_item(mfb_pkg::MODE_WRITE, 8'd200, 8'd0,   8'hFF, 4'd8);   // clipped column
    send_item(mfb_pkg::MODE_WRITE, 8'd0,   8'd255, 8'hFF, 4'd15);  // clipped rows
    send_item(mfb_pkg::MODE_READ,  8'd200, 8'd0,   8'h00, 4'd0);
    send_item(mfb_pkg::MODE_READ,  8'd0,   8'd255, 8'h00, 4'd0);
    send_item(mfb_pkg::MODE_READ,  8'd3,   8'd64,  8'h00, 4'd0);
    send_item(3'd5,                8'd10,  8'd0,   8'h00, 4'd0);   // unused modes
    send_item(3'd6,                8'd10,  8'd0,   8'hFF, 4'd8);
    send_item(3'd7,                8'd10,  8'd0,   8'hFF, 4'd8);
    send_item(mfb_pkg::MODE_CLEAR, 8'd0,   8'd0,   8'h00, 4'd0);
    send_item(mfb_pkg::MODE_READ,  8'd10,  8'd0,   8'h00, 4'd0);
    send_item(mfb_pkg::MODE_GET,   8'd127, 8'd63,  8'h00, 4'd0);

    // Phase one: sender idles 38 percent, receiver 55 percent.
    random_phase();
    wait_for_replies(8);

    // Phase two: the rates swap.
    tx_idle_pct = 55;
    rx_idle_pct = 38;
    random_phase();
    wait_for_replies(8);

    // Phase three: no idling, opened by the receiver's long hold-off.
    tx_idle_pct  = 0;
    rx_idle_pct  = 0;
    long_hold_go = 1'b1;
    random_phase();

    // Let a trailing clear all finish before the verdict.
    wait_for_replies(CLEAR_CYCLES + 50);
    if (error_count == 0 && pending_reads == 0) begin
      $display("mono_framebuffer_blit_engine test passed");
    end else begin
      if (pending_reads != 0)
        $error("%0d reads were never answered", pending_reads);
      $display("mono_framebuffer_blit_engine test failed");
    end
    $finish;
  end

  // Watchdog far beyond the slowest correct run.
  initial begin
    #4_800_000;
    $display("mono_framebuffer_blit_engine test failed");
    $finish;
  end

endmodule

### mono_framebuffer_blit_engine.f
rtl/mfb_pkg.sv
rtl/mfb_ram.sv
rtl/mfb_front.sv
rtl/mfb_queue.sv
rtl/mfb_back.sv
rtl/mono_framebuffer_blit_engine.sv
tb/mfb_checker.sv
tb/mono_framebuffer_blit_engine_test.sv
